>>> rtl/fixed_block_pool_allocator_top_macros.svh
// Assertion macros shared by the checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("fbpa same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("fbpa next-cycle check failed");

`endif

>>> rtl/fbpa_pkg.sv
package fbpa_pkg;

  localparam int ADDR_W         = 32;
  localparam int BLK_W          = 17;
  localparam int STATUS_W       = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int NUM_BLOCKS_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NULL_PTR  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_POOL  = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic load;
    logic advance;
  } step_ctrl_t;

  typedef struct packed {
    logic in_pool;
    logic hit;
  } step_stat_t;

endpackage

>>> rtl/fbpa_cfg_regs.sv
module fbpa_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]         wr_data,
  output logic                                wr_hit,
  output logic [fbpa_pkg::ADDR_W-1:0]         region_base,
  output logic [fbpa_pkg::ADDR_W-1:0]         region_bytes,
  output logic [fbpa_pkg::BLK_W-1:0]          block_bytes
);

  logic [fbpa_pkg::ADDR_W-1:0] base_r;
  logic [fbpa_pkg::ADDR_W-1:0] region_r;
  logic [fbpa_pkg::BLK_W-1:0]  blk_r;

  assign wr_hit = wr_en && (wr_index == fbpa_pkg::REG_REGION_BASE ||
                            wr_index == fbpa_pkg::REG_REGION_BYTES ||
                            wr_index == fbpa_pkg::REG_BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      region_r <= '0;
      blk_r    <= fbpa_pkg::BLK_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        fbpa_pkg::REG_REGION_BASE:  base_r   <= wr_data;
        fbpa_pkg::REG_REGION_BYTES: region_r <= wr_data;
        fbpa_pkg::REG_BLOCK_BYTES:  blk_r    <= wr_data[fbpa_pkg::BLK_W-1:0];
        default: ;
      endcase
    end
  end

  assign region_base  = base_r;
  assign region_bytes = region_r;
  assign block_bytes  = blk_r;

endmodule

>>> rtl/fbpa_step_unit.sv
module fbpa_step_unit #(
  parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                             clk,
  input  fbpa_pkg::step_ctrl_t             ctrl,
  input  logic [fbpa_pkg::ADDR_W-1:0]      region_base,
  input  logic [fbpa_pkg::ADDR_W-1:0]      region_bytes,
  input  logic [fbpa_pkg::BLK_W-1:0]       block_bytes,
  input  logic [fbpa_pkg::ADDR_W-1:0]      target,
  output fbpa_pkg::step_stat_t             stat,
  output logic [fbpa_pkg::ADDR_W-1:0]      block_addr
);

  localparam int END_W = fbpa_pkg::BLK_W + $clog2(NUM_BLOCKS + 1);
  localparam int ACC_W = fbpa_pkg::ADDR_W + 1;

  // acc_r holds the start of the current block, end_r the offset just past it.
  logic [ACC_W-1:0] acc_r;
  logic [END_W-1:0] end_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc_r <= {1'b0, region_base};
      end_r <= END_W'(block_bytes);
    end else if (ctrl.advance) begin
      acc_r <= acc_r + ACC_W'(block_bytes);
      end_r <= end_r + END_W'(block_bytes);
    end
  end

  assign stat.in_pool = (region_base != '0) && (block_bytes != '0) &&
                        (fbpa_pkg::ADDR_W'(end_r) <= region_bytes) && !acc_r[ACC_W-1];
  assign stat.hit     = (acc_r == {1'b0, target});
  assign block_addr   = acc_r[fbpa_pkg::ADDR_W-1:0];

endmodule

>>> rtl/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator.
// Configuration: write region_base (index 0), region_bytes (index 1) and
// block_bytes (index 2) on the cfg_ channel while the block is idle. Every
// transfer to one of these registers marks all blocks free again.
// Requests: an item is taken when start is high and busy is low. An allocate
// returns the lowest free block of the pool; a free returns a block given by
// its exact start address.
// One shared step unit walks the pool one block per cycle, so an item stays
// busy until it reaches the block that decides it (first free block, matching
// block, or end of the pool), never past the last of the NUM_BLOCKS blocks.
// The result appears with out_valid for one cycle right after busy drops, and
// a new item may be taken in that same cycle.
// The receiver cannot stall; every result is a single-cycle transfer.
// After reset the pool is empty (region_base is zero) and all blocks are free.
module fixed_block_pool_allocator_top #(
  parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic [fbpa_pkg::ADDR_W-1:0]        in_block_address,
  output logic                               out_valid,
  output logic [fbpa_pkg::ADDR_W-1:0]        out_granted_address,
  output logic [fbpa_pkg::STATUS_W-1:0]      out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]        cfg_wdata
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                              state_r, state_nxt;
  logic [IDX_W-1:0]                  idx_r, idx_nxt;
  logic [NUM_BLOCKS-1:0]             free_map_r, free_map_nxt;
  logic                              req_r;
  logic [fbpa_pkg::ADDR_W-1:0]       addr_r;
  logic                              out_valid_r, out_valid_nxt;
  logic [fbpa_pkg::ADDR_W-1:0]       grant_r, grant_nxt;
  logic [fbpa_pkg::STATUS_W-1:0]     status_r, status_nxt;

  logic                              accept;
  logic                              cfg_wr;
  logic                              cfg_hit;
  logic [fbpa_pkg::ADDR_W-1:0]       region_base;
  logic [fbpa_pkg::ADDR_W-1:0]       region_bytes;
  logic [fbpa_pkg::BLK_W-1:0]        block_bytes;
  fbpa_pkg::step_ctrl_t              ctrl;
  fbpa_pkg::step_stat_t              stat;
  logic [fbpa_pkg::ADDR_W-1:0]       block_addr;
  logic                              last;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  fbpa_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (cfg_wr),
    .wr_index     (cfg_index),
    .wr_data      (cfg_wdata),
    .wr_hit       (cfg_hit),
    .region_base  (region_base),
    .region_bytes (region_bytes),
    .block_bytes  (block_bytes)
  );

  fbpa_step_unit #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_step (
    .clk          (clk),
    .ctrl         (ctrl),
    .region_base  (region_base),
    .region_bytes (region_bytes),
    .block_bytes  (block_bytes),
    .target       (addr_r),
    .stat         (stat),
    .block_addr   (block_addr)
  );

  assign last = (idx_r == IDX_W'(NUM_BLOCKS - 1));

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    free_map_nxt  = free_map_r;
    out_valid_nxt = 1'b0;
    grant_nxt     = grant_r;
    status_nxt    = status_r;
    ctrl.load     = accept;
    ctrl.advance  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cfg_hit) begin
          free_map_nxt = '1;
        end
        if (accept) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        grant_nxt = '0;
        if (req_r == fbpa_pkg::REQ_FREE && addr_r == '0) begin
          status_nxt    = fbpa_pkg::ST_NULL_PTR;
          out_valid_nxt = 1'b1;
        end else if (!stat.in_pool) begin
          status_nxt    = (req_r == fbpa_pkg::REQ_ALLOC) ? fbpa_pkg::ST_EMPTY
                                                         : fbpa_pkg::ST_NOT_POOL;
          out_valid_nxt = 1'b1;
        end else if (req_r == fbpa_pkg::REQ_ALLOC) begin
          if (free_map_r[idx_r]) begin
            free_map_nxt[idx_r] = 1'b0;
            grant_nxt           = block_addr;
            status_nxt          = fbpa_pkg::ST_OK;
            out_valid_nxt       = 1'b1;
          end else if (last) begin
            status_nxt    = fbpa_pkg::ST_EMPTY;
            out_valid_nxt = 1'b1;
          end else begin
            ctrl.advance = 1'b1;
            idx_nxt      = idx_r + 1'b1;
          end
        end else begin
          if (stat.hit) begin
            free_map_nxt[idx_r] = 1'b1;
            status_nxt          = fbpa_pkg::ST_OK;
            out_valid_nxt       = 1'b1;
          end else if (last) begin
            status_nxt    = fbpa_pkg::ST_NOT_POOL;
            out_valid_nxt = 1'b1;
          end else begin
            ctrl.advance = 1'b1;
            idx_nxt      = idx_r + 1'b1;
          end
        end
        if (out_valid_nxt) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_map_r  <= '1;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      free_map_r  <= free_map_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      addr_r <= in_block_address;
    end
    grant_r  <= grant_nxt;
    status_r <= status_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = grant_r;
  assign out_status          = status_r;

endmodule

>>> rtl/fbpa_checker.sv
`include "fixed_block_pool_allocator_top_macros.svh"

module fbpa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic [fbpa_pkg::ADDR_W-1:0]     out_granted_address,
  input logic [fbpa_pkg::STATUS_W-1:0]   out_status
);

  logic not_ok;

  assign not_ok = (out_status != fbpa_pkg::ST_OK);

  `FBPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `FBPA_ASSERT_SAME(a_result_after_work, out_valid, $past(busy))
  `FBPA_ASSERT_SAME(a_zero_unless_ok, out_valid && not_ok, out_granted_address == '0)
  `FBPA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);
